// ===== rtl/assert_macros.svh =====
// Assertion macros for the voxel ray traversal unit.
// Each macro expects a clock named clk in scope; VRT_ASSERT also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define VRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define VRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vrt_pkg.sv =====
// Shared constants, codes and helpers of the voxel ray traversal unit.
// Used by vrt_sqrt, vrt_div and voxel_ray_traversal_unit; depends on nothing.
`default_nettype none
package vrt_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int POS_W   = 32;
  localparam int DIR_W   = 16;
  localparam int VOX_W   = 16;
  localparam int NRM_W   = 2;
  localparam int T_W     = 32;
  localparam int SUM_W   = 32;
  localparam int SQ_IN_W = 48;
  localparam int LEN_W   = SQ_IN_W / 2;
  localparam int DIST_W  = 17;
  localparam int NUM_W   = DIST_W + LEN_W;
  localparam int DEN_W   = DIR_W;
  localparam int MAXD_W  = 16;

  localparam logic [T_W-1:0]    T_SAT      = '1;
  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(2048);

  localparam logic [2:0] ADDR_MAX_DIST = 3'd0;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_HIT   = 2'd1,
    KIND_MISS  = 2'd2
  } kind_t;

  localparam logic OP_START = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  function automatic logic [VOX_W-1:0] vox_out(input logic [COORD_BITS-1:0] c);
    logic signed [31:0] w;
    w = 32'(signed'(c));
    return w[VOX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vrt_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on vrt_pkg for widths.
`default_nettype none
module vrt_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [vrt_pkg::SQ_IN_W-1:0] radicand,
  output logic                             done,
  output logic [vrt_pkg::LEN_W-1:0]        root
);
  localparam int CNT_W = $clog2(vrt_pkg::LEN_W + 1);

  logic [CNT_W-1:0]              cnt_r;
  logic [vrt_pkg::SQ_IN_W-1:0]   val_r;
  logic [vrt_pkg::LEN_W+1:0]     rem_r;
  logic [vrt_pkg::LEN_W-1:0]     root_r;
  logic                          done_r;
  logic [vrt_pkg::LEN_W+1:0]     rem_sh;
  logic [vrt_pkg::LEN_W+1:0]     trial;

  assign rem_sh = {rem_r[vrt_pkg::LEN_W-1:0], val_r[vrt_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CNT_W'(vrt_pkg::LEN_W);
        val_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (cnt_r != '0) begin
        val_r <= {val_r[vrt_pkg::SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[vrt_pkg::LEN_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[vrt_pkg::LEN_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

// ===== rtl/vrt_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// Depends on vrt_pkg for widths and the saturation value.
`default_nettype none
`include "assert_macros.svh"
module vrt_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [vrt_pkg::NUM_W-1:0] num,
  input  wire logic [vrt_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic [vrt_pkg::T_W-1:0]        quo
);
  localparam int CNT_W = $clog2(vrt_pkg::NUM_W + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic [vrt_pkg::NUM_W-1:0] q_r;
  logic [vrt_pkg::DEN_W-1:0] den_r;
  logic [vrt_pkg::DEN_W-1:0] rem_r;
  logic                      done_r;
  logic [vrt_pkg::DEN_W:0]   rem_sh;
  logic                      fits;

  assign rem_sh = {rem_r, q_r[vrt_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(vrt_pkg::NUM_W);
        q_r   <= num;
        den_r <= den;
        rem_r <= '0;
      end else if (cnt_r != '0) begin
        rem_r <= fits ? vrt_pkg::DEN_W'(rem_sh - {1'b0, den_r})
                      : vrt_pkg::DEN_W'(rem_sh);
        q_r   <= {q_r[vrt_pkg::NUM_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = (|q_r[vrt_pkg::NUM_W-1:vrt_pkg::T_W]) ? vrt_pkg::T_SAT
                                                       : q_r[vrt_pkg::T_W-1:0];

  `VRT_ASSERT(a_div_done_once, done_r |=> !done_r, "divider done held for two cycles")
  `VRT_ASSERT(a_div_idle_done, done_r |-> cnt_r == '0, "divider done while still iterating")
endmodule
`default_nettype wire

// ===== rtl/voxel_ray_traversal_unit.sv =====
// Voxel ray traversal unit: start transactions set up a 3D DDA walk, reply transactions step it.
// A start computes the ray length with vrt_sqrt, then runs the shared 41-step divider twice per
// nonzero direction axis. A reply is written straight into the output register. One transaction
// is in flight at a time. Synchronous active-low reset leaves the unit idle with no ray active
// and max_distance at 8.0. Depends on vrt_pkg, vrt_sqrt, vrt_div.
`default_nettype none
`include "assert_macros.svh"
module voxel_ray_traversal_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_operation,
  input  wire logic [vrt_pkg::POS_W-1:0]  in_origin_x,
  input  wire logic [vrt_pkg::POS_W-1:0]  in_origin_y,
  input  wire logic [vrt_pkg::POS_W-1:0]  in_origin_z,
  input  wire logic [vrt_pkg::DIR_W-1:0]  in_dir_x,
  input  wire logic [vrt_pkg::DIR_W-1:0]  in_dir_y,
  input  wire logic [vrt_pkg::DIR_W-1:0]  in_dir_z,
  input  wire logic                       in_occupied,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_kind,
  output logic [vrt_pkg::VOX_W-1:0]       out_voxel_x,
  output logic [vrt_pkg::VOX_W-1:0]       out_voxel_y,
  output logic [vrt_pkg::VOX_W-1:0]       out_voxel_z,
  output logic [vrt_pkg::NRM_W-1:0]       out_normal_x,
  output logic [vrt_pkg::NRM_W-1:0]       out_normal_y,
  output logic [vrt_pkg::NRM_W-1:0]       out_normal_z,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [2:0]                 cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  localparam int CB = vrt_pkg::COORD_BITS;
  localparam int FB = vrt_pkg::FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQ    = 8'b0000_0010,
    S_SQRT  = 8'b0000_0100,
    S_AXIS  = 8'b0000_1000,
    S_SPC   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_NXTGO = 8'b0100_0000,
    S_NXT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [vrt_pkg::MAXD_W-1:0]   maxd_r;
  logic                         active_r;
  logic [CB-1:0]                cell_r [3];
  logic signed [1:0]            step_r [3];
  logic [vrt_pkg::T_W-1:0]      nb_r   [3];
  logic [vrt_pkg::T_W-1:0]      sp_r   [3];
  logic signed [1:0]            face_r [3];
  logic [15:0]                  frac_r [3];
  logic signed [vrt_pkg::DIR_W-1:0] dir_r [3];
  logic [1:0]                   sq_cnt_r;
  logic [1:0]                   ax_r;
  logic [vrt_pkg::SUM_W-1:0]    sum_r;
  logic [vrt_pkg::LEN_W-1:0]    len_r;
  logic [vrt_pkg::NUM_W-1:0]    prod_r;

  logic                         out_valid_r;
  vrt_pkg::kind_t               out_kind_r;
  logic [vrt_pkg::VOX_W-1:0]    out_vox_r [3];
  logic [vrt_pkg::NRM_W-1:0]    out_nrm_r [3];

  logic [vrt_pkg::POS_W-1:0]    in_org [3];
  logic [vrt_pkg::DIR_W-1:0]    in_dir [3];
  logic                         in_acc;
  logic                         cfg_wr;

  logic                         sqrt_start, sqrt_done;
  logic [vrt_pkg::LEN_W-1:0]    sqrt_root;
  logic                         div_start, div_done;
  logic [vrt_pkg::NUM_W-1:0]    div_num;
  logic [vrt_pkg::T_W-1:0]      div_quo;

  logic signed [31:0]           sq_val;
  logic [vrt_pkg::DIST_W-1:0]   bnd_dist;
  logic [vrt_pkg::DEN_W-1:0]    mag;

  logic [1:0]                   ax;
  logic [vrt_pkg::T_W-1:0]      walked;
  logic [vrt_pkg::T_W:0]        nb_sum;
  logic [vrt_pkg::T_W-1:0]      limit;

  assign in_org = '{in_origin_x, in_origin_y, in_origin_z};
  assign in_dir = '{in_dir_x, in_dir_y, in_dir_z};

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == vrt_pkg::ADDR_MAX_DIST) ? 32'(maxd_r) : 32'd0;

  assign sq_val = dir_r[sq_cnt_r] * dir_r[sq_cnt_r];
  assign mag    = dir_r[ax_r][vrt_pkg::DIR_W-1] ? vrt_pkg::DEN_W'(-dir_r[ax_r])
                                                : vrt_pkg::DEN_W'(dir_r[ax_r]);
  assign bnd_dist = (step_r[ax_r] > 2'sd0)
                    ? vrt_pkg::DIST_W'(17'h10000 - {1'b0, frac_r[ax_r]})
                    : vrt_pkg::DIST_W'(frac_r[ax_r]);

  assign sqrt_start = (state_r == S_SQ) && (sq_cnt_r == 2'd3);
  assign div_start  = ((state_r == S_AXIS) && (dir_r[ax_r] != '0)) || (state_r == S_NXTGO);
  assign div_num    = (state_r == S_AXIS) ? (vrt_pkg::NUM_W'(len_r) << (FB - 8))
                                          : (prod_r >> (24 - FB));

  always_comb begin
    if (nb_r[0] < nb_r[1] && nb_r[0] < nb_r[2]) begin
      ax = 2'd0;
    end else if (nb_r[1] < nb_r[2]) begin
      ax = 2'd1;
    end else begin
      ax = 2'd2;
    end
  end

  assign walked = nb_r[ax];
  assign nb_sum = {1'b0, nb_r[ax]} + {1'b0, sp_r[ax]};
  assign limit  = vrt_pkg::T_W'(maxd_r) << (FB - 8);

  vrt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand ({sum_r, 16'h0000}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  vrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_operation == vrt_pkg::OP_START) state_nxt = S_SQ;
      S_SQ:    if (sq_cnt_r == 2'd3) state_nxt = S_SQRT;
      S_SQRT:  if (sqrt_done) state_nxt = S_AXIS;
      S_AXIS: begin
        if (dir_r[ax_r] != '0) begin
          state_nxt = S_SPC;
        end else if (ax_r == 2'd2) begin
          state_nxt = S_IDLE;
        end
      end
      S_SPC:   if (div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_NXTGO;
      S_NXTGO: state_nxt = S_NXT;
      S_NXT:   if (div_done) state_nxt = (ax_r == 2'd2) ? S_IDLE : S_AXIS;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      maxd_r      <= vrt_pkg::MAXD_RESET;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sq_cnt_r    <= '0;
      ax_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == vrt_pkg::ADDR_MAX_DIST) begin
        maxd_r <= cfg_pwdata[vrt_pkg::MAXD_W-1:0];
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_operation == vrt_pkg::OP_START) begin
            for (int a = 0; a < 3; a++) begin
              cell_r[a] <= CB'(signed'(in_org[a][31:16]));
              frac_r[a] <= in_org[a][15:0];
              dir_r[a]  <= in_dir[a];
              face_r[a] <= 2'sd0;
              step_r[a] <= (in_dir[a] == '0) ? 2'sd0
                         : (in_dir[a][vrt_pkg::DIR_W-1] ? -2'sd1 : 2'sd1);
            end
            sum_r    <= '0;
            sq_cnt_r <= '0;
            ax_r     <= '0;
          end else if (in_acc && active_r) begin
            if (in_occupied) begin
              active_r    <= 1'b0;
              out_valid_r <= 1'b1;
              out_kind_r  <= vrt_pkg::KIND_HIT;
              for (int a = 0; a < 3; a++) begin
                out_vox_r[a] <= vrt_pkg::vox_out(cell_r[a]);
                out_nrm_r[a] <= face_r[a];
              end
            end else begin
              nb_r[ax] <= nb_sum[vrt_pkg::T_W] ? vrt_pkg::T_SAT : nb_sum[vrt_pkg::T_W-1:0];
              for (int a = 0; a < 3; a++) begin
                face_r[a]    <= (ax == 2'(a)) ? -step_r[a] : 2'sd0;
                out_nrm_r[a] <= '0;
              end
              cell_r[ax]  <= cell_r[ax] + CB'(step_r[ax]);
              out_valid_r <= 1'b1;
              if (walked > limit) begin
                active_r   <= 1'b0;
                out_kind_r <= vrt_pkg::KIND_MISS;
                for (int a = 0; a < 3; a++) begin
                  out_vox_r[a] <= '0;
                end
              end else begin
                out_kind_r <= vrt_pkg::KIND_QUERY;
                for (int a = 0; a < 3; a++) begin
                  out_vox_r[a] <= (ax == 2'(a)) ? vrt_pkg::vox_out(cell_r[a] + CB'(step_r[a]))
                                                : vrt_pkg::vox_out(cell_r[a]);
                end
              end
            end
          end
        end
        S_SQ: begin
          if (sq_cnt_r != 2'd3) begin
            sum_r <= sum_r + vrt_pkg::SUM_W'(sq_val);
          end
          sq_cnt_r <= sq_cnt_r + 2'd1;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            len_r <= sqrt_root;
          end
        end
        S_AXIS: begin
          if (dir_r[ax_r] == '0) begin
            nb_r[ax_r] <= vrt_pkg::T_SAT;
            sp_r[ax_r] <= vrt_pkg::T_SAT;
            if (ax_r == 2'd2) begin
              active_r    <= 1'b1;
              out_valid_r <= 1'b1;
              out_kind_r  <= vrt_pkg::KIND_QUERY;
              for (int a = 0; a < 3; a++) begin
                out_vox_r[a] <= vrt_pkg::vox_out(cell_r[a]);
                out_nrm_r[a] <= '0;
              end
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        S_SPC: begin
          if (div_done) begin
            sp_r[ax_r] <= div_quo;
          end
        end
        S_MUL: begin
          prod_r <= vrt_pkg::NUM_W'(bnd_dist) * vrt_pkg::NUM_W'(len_r);
        end
        S_NXTGO: begin
        end
        S_NXT: begin
          if (div_done) begin
            nb_r[ax_r] <= div_quo;
            if (ax_r == 2'd2) begin
              active_r    <= 1'b1;
              out_valid_r <= 1'b1;
              out_kind_r  <= vrt_pkg::KIND_QUERY;
              for (int a = 0; a < 3; a++) begin
                out_vox_r[a] <= vrt_pkg::vox_out(cell_r[a]);
                out_nrm_r[a] <= '0;
              end
            end else begin
              ax_r <= ax_r + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_voxel_x  = out_vox_r[0];
  assign out_voxel_y  = out_vox_r[1];
  assign out_voxel_z  = out_vox_r[2];
  assign out_normal_x = out_nrm_r[0];
  assign out_normal_y = out_nrm_r[1];
  assign out_normal_z = out_nrm_r[2];

  `VRT_ASSERT(a_len_nonzero,
              sqrt_done && sum_r != '0 |-> sqrt_root != '0,
              "zero length for nonzero direction")
  `VRT_ASSERT(a_div_in_wait,
              div_done |-> state_r == S_SPC || state_r == S_NXT,
              "divider result outside a wait state")
  `VRT_ASSERT(a_query_active,
              $rose(out_valid_r) && out_kind_r == vrt_pkg::KIND_QUERY |-> active_r,
              "query issued without an active ray")
  `VRT_ASSERT(a_miss_zero,
              out_valid_r && out_kind_r == vrt_pkg::KIND_MISS |->
                out_vox_r[0] == '0 && out_nrm_r[0] == '0,
              "miss carries a voxel")
endmodule
`default_nettype wire

// ===== sim/voxel_ray_traversal_unit_tb.sv =====
// Self-checking testbench for the voxel ray traversal unit: directed and random rays,
// with occupancy replies, are predicted in place and checked against every output transaction.
// Depends on vrt_pkg and voxel_ray_traversal_unit.
`default_nettype none
module voxel_ray_traversal_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic                           op;
    logic [2:0][vrt_pkg::POS_W-1:0] origin;
    logic [2:0][vrt_pkg::DIR_W-1:0] dir;
    logic                           occupied;
  } ray_cmd_t;

  typedef struct {
    vrt_pkg::kind_t                 kind;
    logic [2:0][vrt_pkg::VOX_W-1:0] vox;
    logic [2:0][vrt_pkg::NRM_W-1:0] nrm;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [vrt_pkg::POS_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic [vrt_pkg::DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic in_occupied = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [vrt_pkg::VOX_W-1:0] out_voxel_x, out_voxel_y, out_voxel_z;
  logic [vrt_pkg::NRM_W-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  voxel_ray_traversal_unit dut (.*);

  ray_cmd_t     ray_cmds[$];
  walk_result_t expected_results[$];
  int           mismatch_count = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;

  // Private copy of the walker state.
  logic [vrt_pkg::MAXD_W-1:0]     max_dist_q88 = vrt_pkg::MAXD_RESET;
  logic [2:0][vrt_pkg::VOX_W-1:0] cur_cell;
  int                             step_dir[3];
  logic [2:0][vrt_pkg::T_W-1:0]   next_t;
  logic [2:0][vrt_pkg::T_W-1:0]   delta_t;
  logic [vrt_pkg::T_W-1:0]        walked;
  int                             face[3];
  logic                           ray_active = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [vrt_pkg::T_W-1:0] sat_t(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? vrt_pkg::T_SAT : v[vrt_pkg::T_W-1:0];
  endfunction

  function automatic void push_walk_result(input vrt_pkg::kind_t k, input bit with_cell,
                                           input bit with_normal);
    walk_result_t r;
    r.kind = k;
    for (int a = 0; a < 3; a++) begin
      r.vox[a] = with_cell ? cur_cell[a] : '0;
      r.nrm[a] = with_normal ? vrt_pkg::NRM_W'(face[a]) : '0;
    end
    expected_results.push_back(r);
  endfunction

  function automatic void walk_predict(input ray_cmd_t c);
    longint ds[3];
    logic [63:0] sum, len, mag, bnd_dist, lim;
    int ax;
    if (c.op == vrt_pkg::OP_START) begin
      sum = '0;
      for (int a = 0; a < 3; a++) begin
        ds[a] = longint'($signed(c.dir[a]));
        sum = sum + 64'(ds[a] * ds[a]);
      end
      len = int_sqrt(sum << 16);
      for (int a = 0; a < 3; a++) begin
        cur_cell[a] = c.origin[a][31:16];
        face[a] = 0;
        if (ds[a] == 0 || len == 0) begin
          step_dir[a] = 0;
          delta_t[a] = vrt_pkg::T_SAT;
          next_t[a] = vrt_pkg::T_SAT;
        end else begin
          step_dir[a] = ds[a] > 0 ? 1 : -1;
          mag = 64'(ds[a] > 0 ? ds[a] : -ds[a]);
          delta_t[a] = sat_t((len << vrt_pkg::FRAC_BITS) / (mag << 8));
          bnd_dist = step_dir[a] > 0 ? 64'd65536 - 64'(c.origin[a][15:0])
                                     : 64'(c.origin[a][15:0]);
          next_t[a] = sat_t(((bnd_dist * len) << vrt_pkg::FRAC_BITS) / (mag << 24));
        end
      end
      walked = '0;
      ray_active = 1'b1;
      push_walk_result(vrt_pkg::KIND_QUERY, 1'b1, 1'b0);
    end else if (ray_active) begin
      if (c.occupied) begin
        ray_active = 1'b0;
        push_walk_result(vrt_pkg::KIND_HIT, 1'b1, 1'b1);
      end else begin
        if (next_t[0] < next_t[1] && next_t[0] < next_t[2]) ax = 0;
        else if (next_t[1] < next_t[2]) ax = 1;
        else ax = 2;
        walked = next_t[ax];
        next_t[ax] = sat_t(64'(next_t[ax]) + 64'(delta_t[ax]));
        for (int a = 0; a < 3; a++) face[a] = 0;
        face[ax] = -step_dir[ax];
        cur_cell[ax] = cur_cell[ax] + vrt_pkg::VOX_W'(step_dir[ax]);
        lim = 64'(max_dist_q88) << (vrt_pkg::FRAC_BITS - 8);
        if (64'(walked) > lim) begin
          ray_active = 1'b0;
          push_walk_result(vrt_pkg::KIND_MISS, 1'b0, 1'b0);
        end else begin
          push_walk_result(vrt_pkg::KIND_QUERY, 1'b1, 1'b0);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $realtime, what);
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        walk_predict(ray_cmds[0]);
        void'(ray_cmds.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (ray_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_operation <= ray_cmds[0].op;
          in_origin_x <= ray_cmds[0].origin[0];
          in_origin_y <= ray_cmds[0].origin[1];
          in_origin_z <= ray_cmds[0].origin[2];
          in_dir_x <= ray_cmds[0].dir[0];
          in_dir_y <= ray_cmds[0].dir[1];
          in_dir_z <= ray_cmds[0].dir[2];
          in_occupied <= ray_cmds[0].occupied;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    walk_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction, kind %0d", out_kind));
        end else begin
          e = expected_results.pop_front();
          if (out_kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_kind, e.kind));
          if (out_voxel_x !== e.vox[0])
            report_mismatch($sformatf("voxel_x %0h, want %0h", out_voxel_x, e.vox[0]));
          if (out_voxel_y !== e.vox[1])
            report_mismatch($sformatf("voxel_y %0h, want %0h", out_voxel_y, e.vox[1]));
          if (out_voxel_z !== e.vox[2])
            report_mismatch($sformatf("voxel_z %0h, want %0h", out_voxel_z, e.vox[2]));
          if (out_normal_x !== e.nrm[0])
            report_mismatch($sformatf("normal_x %0h, want %0h", out_normal_x, e.nrm[0]));
          if (out_normal_y !== e.nrm[1])
            report_mismatch($sformatf("normal_y %0h, want %0h", out_normal_y, e.nrm[1]));
          if (out_normal_z !== e.nrm[2])
            report_mismatch($sformatf("normal_z %0h, want %0h", out_normal_z, e.nrm[2]));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on lack of progress while work is outstanding.
  always @(posedge clk) begin
    if (rst_n && (ray_cmds.size() > 0 || expected_results.size() > 0)) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  function automatic void push_start(input logic [31:0] ox, input logic [31:0] oy,
                                     input logic [31:0] oz, input logic [15:0] dx,
                                     input logic [15:0] dy, input logic [15:0] dz);
    ray_cmd_t c;
    c.op = vrt_pkg::OP_START;
    c.origin[0] = ox; c.origin[1] = oy; c.origin[2] = oz;
    c.dir[0] = dx; c.dir[1] = dy; c.dir[2] = dz;
    c.occupied = 1'($urandom_range(1));
    ray_cmds.push_back(c);
  endfunction

  function automatic void push_reply(input logic occ);
    ray_cmd_t c;
    c.op = vrt_pkg::OP_REPLY;
    for (int a = 0; a < 3; a++) begin
      c.origin[a] = $urandom();
      c.dir[a] = 16'($urandom());
    end
    c.occupied = occ;
    ray_cmds.push_back(c);
  endfunction

  function automatic logic [31:0] rand_origin();
    if ($urandom_range(1)) return $urandom();
    return {16'($signed($urandom_range(32)) - 16), 16'($urandom())};
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(9))
      0, 1: return '0;
      2: return 16'($signed($urandom_range(6)) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic write_max_distance(input logic [vrt_pkg::MAXD_W-1:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= vrt_pkg::ADDR_MAX_DIST;
    cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    max_dist_q88 = v;
  endtask

  task automatic drain();
    wait (ray_cmds.size() == 0 && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    logic [vrt_pkg::MAXD_W-1:0] phase_max[4];
    int phase_items[4];
    phase_max[0] = '0;
    phase_max[1] = '1;
    phase_max[2] = vrt_pkg::MAXD_W'($urandom());
    phase_max[3] = vrt_pkg::MAXD_W'(768);
    phase_items[0] = 60;
    phase_items[1] = 280;
    phase_items[2] = 280;
    phase_items[3] = 280;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rays at the reset distance limit.
    send_idle_pct = 20;
    recv_stall_pct = 49;
    push_reply(1'b0);
    push_reply(1'b1);
    push_start(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, '0, '0, '0);
    push_reply(1'b0);
    push_start(32'h0003_0000, 32'hFFFE_4000, 32'h0000_0001, 16'h4000, 16'h4000, 16'h4000);
    push_reply(1'b1);
    push_start(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h1000, 16'h1000, 16'h1000);
    repeat (4) push_reply(1'b0);
    push_reply(1'b1);
    push_start(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    repeat (3) push_reply(1'b0);
    push_start(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h7FFF, 16'h8000, 16'h0001);
    push_reply(1'b0);
    push_start(32'h0001_0000, 32'h0000_0000, 32'hFFFF_0000, 16'h0000, 16'hC000, 16'h0000);
    repeat (5) push_reply(1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 2) ? 49 : (ph == 3) ? 0 : 20;
      recv_stall_pct = (ph == 2) ? 20 : (ph == 3) ? 0 : 49;
      write_max_distance(phase_max[ph]);
      @(negedge clk);
      n = 0;
      while (n < phase_items[ph]) begin
        if ($urandom_range(9) == 0) begin
          push_reply(1'($urandom_range(1)));
          n++;
        end
        push_start(rand_origin(), rand_origin(), rand_origin(),
                   rand_dir(), rand_dir(), rand_dir());
        n++;
        for (int k = $urandom_range(40, 1); k > 0; k--) begin
          push_reply($urandom_range(19) == 0);
          n++;
        end
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
